[rtl/kal_pkg.sv]
// Shared types, constants and the key clean-up function for the keyed allow list.
// No dependencies; imported by kal_table, keyed_allow_list_with_expiry and its testbench.
package kal_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BYTES   = 16;
    localparam int KEY_LEN     = KEY_BYTES - 1;
    localparam int KEY_W       = 8 * KEY_LEN;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DATE_W      = 27;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 2'd0,
        FN_ADD   = 2'd1,
        FN_MATCH = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_ENTRY    = 3'd1,
        ST_EXPIRED     = 3'd2,
        ST_NOT_ALLOWED = 3'd3,
        ST_REJECTED    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              permit;
        logic [DATE_W-1:0] expiry;
    } t_entry;

    // compare stage result, one per read issued
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic              permit;
        logic [DATE_W-1:0] expiry;
    } t_cmp;

    // zero every byte from the first zero byte onwards
    function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             alive;
        res   = '0;
        alive = 1'b1;
        for (int b = 0; b < KEY_LEN; b++) begin
            alive = alive & (raw[8*b +: 8] != 8'd0);
            if (alive) begin
                res[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

[rtl/kal_table.sv]
// Entry store of the allow list: one synchronous memory with a registered read port
// and the key compare on the read data. Depends on kal_pkg.
module kal_table
    import kal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_entry,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic [KEY_W-1:0]  i_key,
    output t_cmp              o_cmp
);

    t_entry mem [MAX_ENTRIES];
    t_entry r_rd;
    logic   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign o_cmp.vld    = r_rd_vld;
    assign o_cmp.hit    = (r_rd.key == i_key);
    assign o_cmp.permit = r_rd.permit;
    assign o_cmp.expiry = r_rd.expiry;

endmodule

[rtl/keyed_allow_list_with_expiry.sv]
// Keyed allow list with expiry: append-only exact-match table with an output register.
// Depends on kal_pkg and kal_table.
//
// One transfer in gives one transfer out. An item is taken only while the block is idle;
// a clear, an add or an unused code goes straight to the push state, and a match with a
// non-empty key on a non-empty table first passes through the scan state, where the scan
// reads the entry memory once per cycle in order of addition and stops at the first
// equal key. A new item may be taken while the previous result still waits on the
// master side. Keys end at their first zero byte. The memory needs no clearing after
// reset; only entries below the count are ever read.
module keyed_allow_list_with_expiry
    import kal_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] key_low, [119:64] key_high, [120] permit, [147:121] entry_expiry,
    // [174:148] today, [175] zero
    input  logic [175:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [9:3] entry_count, [15:10] zero
    output logic [15:0]  m_axis_tdata
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [DATE_W-1:0] r_today, n_today;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_data, n_out_data;

    logic              acc;
    logic [KEY_W-1:0]  key_in;
    logic              key_empty;
    logic              full;
    logic              wr_en;
    logic              rd_en;
    logic              out_load;
    t_entry            wr_entry;
    t_cmp              cmp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc           = s_axis_tvalid & s_axis_tready;
    assign key_in        = clean_key(s_axis_tdata[KEY_W-1:0]);
    assign key_empty     = (key_in == '0);
    assign full          = (r_count >= CNT_W'(MAX_ENTRIES));

    assign wr_entry.key    = key_in;
    assign wr_entry.permit = s_axis_tdata[120];
    assign wr_entry.expiry = s_axis_tdata[147:121];

    kal_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[ADDR_W-1:0]),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_issue[ADDR_W-1:0]),
        .i_key      (r_key),
        .o_cmp      (cmp)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_issue   = r_issue;
        n_key     = r_key;
        n_today   = r_today;
        n_status  = r_status;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state  = S_PUSH;
                    n_status = ST_OK;
                    case (t_func'(s_axis_tuser))
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        FN_ADD: begin
                            if (key_empty || full) begin
                                n_status = ST_REJECTED;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        FN_MATCH: begin
                            n_key    = key_in;
                            n_today  = s_axis_tdata[174:148];
                            n_status = ST_NO_ENTRY;
                            n_issue  = '0;
                            if (!key_empty && r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                rd_en = (r_issue < r_count);
                if (rd_en) begin
                    n_issue = r_issue + 1'b1;
                end
                // the read issued last cycle is compared now
                if (cmp.vld && cmp.hit) begin
                    n_state = S_PUSH;
                    if (!cmp.permit) begin
                        n_status = ST_NOT_ALLOWED;
                    end else if (cmp.expiry != '0 && r_today > cmp.expiry) begin
                        n_status = ST_EXPIRED;
                    end else begin
                        n_status = ST_OK;
                    end
                end else if (!cmp.vld && !rd_en) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid & ~m_axis_tready) | out_load;
    assign n_out_data  = out_load ? {6'd0, COUNT_W'(r_count), r_status} : r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_today    <= n_today;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_axis_tuser == FN_ADD && !key_empty && !full)
        |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("accepted add did not grow the table");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_issue <= r_count)
        else $error("scan read past the last entry");

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_PUSH))
        else $error("result shown without a pending result");
`endif

endmodule

[verif/keyed_allow_list_with_expiry_tb.sv]
// Self-checking testbench for keyed_allow_list_with_expiry: directed and random table traffic.
// Depends on kal_pkg and the RTL; a local table model predicts every status and entry count.
module keyed_allow_list_with_expiry_tb;
    import kal_pkg::*;

    localparam logic [1:0]        FN_NOP   = 2'd3;
    localparam logic [DATE_W-1:0] DATE_MAX = {DATE_W{1'b1}};
    localparam int                QUIET_TAIL = 150;
    localparam int                HOLD_AFTER = 300;
    localparam int                HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic              permit;
        logic [DATE_W-1:0] expiry;
        logic [DATE_W-1:0] today;
        bit                hold;
    } t_req;

    typedef struct {
        t_status             status;
        logic [COUNT_W-1:0]  count;
    } t_result;

    typedef struct {
        logic [KEY_W-1:0]  key;
        logic [DATE_W-1:0] expiry;
    } t_live;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [63:0] key_low, [119:64] key_high, [120] permit, [147:121] entry_expiry,
    // [174:148] today, [175] zero
    logic [175:0] s_axis_tdata = '0;
    // [1:0] func
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [2:0] status, [9:3] entry_count, [15:10] zero
    logic [15:0]  m_axis_tdata;

    keyed_allow_list_with_expiry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial forever #2 i_clk = ~i_clk;

    // model of the table contents
    logic [KEY_W-1:0]  tab_key    [MAX_ENTRIES];
    logic              tab_permit [MAX_ENTRIES];
    logic [DATE_W-1:0] tab_expiry [MAX_ENTRIES];
    int                tab_fill = 0;

    t_req    pending[$];
    t_result results_due[$];
    t_live   live_keys[$];
    int      n_offered = 0;
    int      n_taken = 0;
    int      n_checked = 0;
    int      n_fail = 0;
    int      status_seen[5] = '{default: 0};
    int      src_idle = 0;
    int      snk_idle = 0;
    int      snk_hold_left = 0;
    bit      snk_hold_done = 1'b0;
    t_req    drv_req;

    function automatic int key_len_of(logic [KEY_W-1:0] k);
        for (int b = 0; b < KEY_LEN; b++) begin
            if (k[8*b +: 8] == 8'd0) return b;
        end
        return KEY_LEN;
    endfunction

    // everything from the first zero byte on counts as zero
    function automatic logic [KEY_W-1:0] trimmed(logic [KEY_W-1:0] k, int n);
        logic [KEY_W-1:0] mask;
        mask = (n == 0) ? '0 : ({KEY_W{1'b1}} >> (8 * (KEY_LEN - n)));
        return k & mask;
    endfunction

    function automatic t_result predict_outcome(logic [1:0] op, logic [KEY_W-1:0] raw,
                                                logic permit, logic [DATE_W-1:0] expiry,
                                                logic [DATE_W-1:0] today);
        t_result          r;
        int               n;
        logic [KEY_W-1:0] k;
        bit               found;
        n        = key_len_of(raw);
        k        = trimmed(raw, n);
        found    = 1'b0;
        r.status = ST_OK;
        case (op)
            FN_CLEAR: begin
                tab_fill = 0;
            end
            FN_ADD: begin
                if (n == 0 || tab_fill >= MAX_ENTRIES) begin
                    r.status = ST_REJECTED;
                end else begin
                    tab_key[tab_fill]    = k;
                    tab_permit[tab_fill] = permit;
                    tab_expiry[tab_fill] = expiry;
                    tab_fill++;
                end
            end
            FN_MATCH: begin
                r.status = ST_NO_ENTRY;
                if (n != 0) begin
                    for (int i = 0; i < tab_fill && !found; i++) begin
                        if (tab_key[i] == k) begin
                            found = 1'b1;
                            if (!tab_permit[i])
                                r.status = ST_NOT_ALLOWED;
                            else if (tab_expiry[i] != 0 && today > tab_expiry[i])
                                r.status = ST_EXPIRED;
                            else
                                r.status = ST_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = tab_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic bit quiet();
        return pending.size() < QUIET_TAIL;
    endfunction

    // ---------------- stimulus construction ----------------

    task automatic queue_req(logic [1:0] op, logic [KEY_W-1:0] key, logic permit,
                             logic [DATE_W-1:0] expiry, logic [DATE_W-1:0] today, bit hold);
        t_req r;
        r.op     = op;
        r.key    = key;
        r.permit = permit;
        r.expiry = expiry;
        r.today  = today;
        r.hold   = hold;
        pending.push_back(r);
    endtask

    // random bytes after the terminating zero, sometimes
    function automatic logic [KEY_W-1:0] with_tail(logic [KEY_W-1:0] k);
        int n;
        n = key_len_of(k);
        if ($urandom_range(0, 1) == 0) begin
            for (int b = n + 1; b < KEY_LEN; b++) begin
                if ($urandom_range(0, 1) == 0) k[8*b +: 8] = 8'($urandom);
            end
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key(int n);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int b = 0; b < n; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
        return with_tail(k);
    endfunction

    function automatic logic [DATE_W-1:0] pick_date();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DATE_MAX;
            2: return DATE_W'(99991231);
            3: return DATE_W'($urandom);
            default: return DATE_W'($urandom_range(19700101, 20991231));
        endcase
    endfunction

    task automatic queue_add(logic [KEY_W-1:0] key, bit hold);
        t_live e;
        e.key    = trimmed(key, key_len_of(key));
        e.expiry = pick_date();
        queue_req(FN_ADD, key, $urandom_range(0, 3) != 0, e.expiry, pick_date(), hold);
        if (key_len_of(key) != 0) live_keys.push_back(e);
    endtask

    task automatic queue_match(bit hold);
        t_live             e;
        logic [KEY_W-1:0]  k;
        logic [DATE_W-1:0] t;
        int                n;
        e = live_keys[$urandom_range(0, live_keys.size() - 1)];
        k = e.key;
        n = key_len_of(k);
        case ($urandom_range(0, 9))
            6: if (n > 1) k[8*(n-1) +: 8] = 8'd0;               // proper prefix
            7: k[7:0] = (k[7:0] == 8'hFF) ? 8'h01 : k[7:0] + 8'd1; // near miss
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: t = e.expiry;
            1: t = e.expiry + 1'b1;
            2: t = e.expiry - 1'b1;
            3: t = pick_date();
            4: t = '0;
            default: t = DATE_MAX;
        endcase
        queue_req(FN_MATCH, with_tail(k), 1'($urandom), DATE_W'($urandom), t, hold);
    endtask

    task automatic queue_episode();
        int n_add;
        int n_look;
        bit hold;
        hold = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) != 0) begin
            queue_req(FN_CLEAR, fresh_key($urandom_range(0, KEY_LEN)), 1'($urandom),
                      DATE_W'($urandom), DATE_W'($urandom), hold);
            live_keys.delete();
        end else begin
            queue_req(FN_NOP, fresh_key($urandom_range(0, KEY_LEN)), 1'($urandom),
                      DATE_W'($urandom), DATE_W'($urandom), hold);
        end
        n_add  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
        n_look = n_add / 2 + 2;
        while (n_add > 0 || n_look > 0) begin
            case ($urandom_range(0, 19))
                0: queue_req(FN_ADD, fresh_key(0), 1'($urandom), DATE_W'($urandom),
                             DATE_W'($urandom), 1'b0);
                1: queue_req(FN_NOP, fresh_key($urandom_range(0, KEY_LEN)), 1'($urandom),
                             DATE_W'($urandom), DATE_W'($urandom), 1'b0);
                2: queue_req(FN_MATCH, fresh_key($urandom_range(1, KEY_LEN)), 1'($urandom),
                             DATE_W'($urandom), pick_date(), 1'b0);
                3: queue_req(FN_MATCH, fresh_key(0), 1'($urandom), DATE_W'($urandom),
                             pick_date(), 1'b0);
                default: begin
                    if (n_add > 0 && (live_keys.size() == 0 || $urandom_range(0, 1) == 0))
                    begin
                        // duplicates now and then, so first-match order matters
                        if (live_keys.size() != 0 && $urandom_range(0, 5) == 0)
                            queue_add(with_tail(live_keys[$urandom_range(0,
                                      live_keys.size() - 1)].key), 1'b0);
                        else
                            queue_add(fresh_key($urandom_range(1, KEY_LEN)), 1'b0);
                        n_add--;
                    end else if (live_keys.size() != 0) begin
                        queue_match(1'b0);
                        n_look--;
                    end else begin
                        n_look--;
                    end
                end
            endcase
        end
    endtask

    task automatic queue_directed();
        logic [KEY_W-1:0] k_full;
        logic [KEY_W-1:0] k_abc;
        k_full = {KEY_LEN{8'hFF}};
        k_abc  = KEY_W'(24'h434241);
        queue_req(FN_MATCH, k_abc, 1'b0, '0, '0, 1'b0);                  // empty table
        queue_req(FN_ADD, KEY_W'(16'h5500), 1'b1, '0, '0, 1'b0);          // empty key
        queue_req(FN_ADD, k_full, 1'b1, '0, DATE_MAX, 1'b0);              // longest key
        queue_req(FN_MATCH, k_full, 1'b0, '0, DATE_MAX, 1'b0);            // never expires
        queue_req(FN_ADD, KEY_W'(8'h01), 1'b0, DATE_MAX, '0, 1'b0);
        queue_req(FN_MATCH, KEY_W'(8'h01), 1'b1, DATE_MAX, '0, 1'b0);     // not allowed
        queue_req(FN_ADD, k_abc, 1'b1, DATE_W'(20240101), '0, 1'b0);
        queue_req(FN_MATCH, k_abc, 1'b0, '0, DATE_W'(20240101), 1'b0);    // on the day
        queue_req(FN_MATCH, k_abc, 1'b0, '0, DATE_W'(20240102), 1'b0);    // day after
        queue_req(FN_MATCH, k_abc, 1'b0, '0, '0, 1'b0);
        queue_req(FN_ADD, k_abc, 1'b0, '0, '0, 1'b0);                     // duplicate
        queue_req(FN_MATCH, k_abc, 1'b0, '0, DATE_W'(20231231), 1'b0);
        queue_req(FN_MATCH, KEY_W'(40'hAA00434241), 1'b0, '0, '0, 1'b0);  // junk after zero
        queue_req(FN_MATCH, KEY_W'(16'h4241), 1'b0, '0, '0, 1'b0);        // prefix only
        queue_req(FN_MATCH, KEY_W'(16'h4200), 1'b0, '0, '0, 1'b0);        // empty key
        queue_req(FN_NOP, k_full, 1'b1, DATE_MAX, DATE_MAX, 1'b0);
        queue_req(FN_CLEAR, '0, 1'b0, '0, '0, 1'b0);
        queue_req(FN_MATCH, k_abc, 1'b0, '0, '0, 1'b0);
        queue_req(FN_ADD, {8'h80, {(KEY_LEN-1){8'h7F}}}, 1'b1, DATE_W'(99991231),
                  '0, 1'b0);
        queue_req(FN_MATCH, {8'h80, {(KEY_LEN-1){8'h7F}}}, 1'b1, '0, DATE_MAX, 1'b0);
    endtask

    // ---------------- driver: source side ----------------

    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && n_offered != n_taken)) begin
            if (src_idle > 0) begin
                src_idle--;
                s_axis_tvalid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending[0].hold && results_due.size() != 0) begin
                s_axis_tvalid <= 1'b0;   // let the block drain before this one
            end else if (!quiet() && $urandom_range(0, 4) == 0) begin
                src_idle = $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end else begin
                drv_req = pending.pop_front();
                s_axis_tdata  <= {1'b0, drv_req.today, drv_req.expiry, drv_req.permit,
                                  drv_req.key};
                s_axis_tuser  <= drv_req.op;
                s_axis_tvalid <= 1'b1;
                n_offered++;
            end
        end
    end

    // ---------------- sink side ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (snk_hold_left > 0) begin
            snk_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!snk_hold_done && n_taken >= HOLD_AFTER) begin
            // long stall so the block backs up onto its input
            snk_hold_done = 1'b1;
            snk_hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (snk_idle > 0) begin
            snk_idle--;
            m_axis_tready <= 1'b0;
        end else if (!quiet() && $urandom_range(0, 4) == 0) begin
            snk_idle = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- monitor: predict on input transfer, check on output transfer ----------

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(predict_outcome(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
                                                      s_axis_tdata[120],
                                                      s_axis_tdata[147:121],
                                                      s_axis_tdata[174:148]));
                n_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    exp_res = results_due.pop_front();
                    n_checked++;
                    status_seen[exp_res.status]++;
                    if (m_axis_tdata[2:0] !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status,
                               m_axis_tdata[2:0]);
                        n_fail++;
                    end
                    if (m_axis_tdata[9:3] !== exp_res.count) begin
                        $error("entry_count: expected %0d, got %0d", exp_res.count,
                               m_axis_tdata[9:3]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        queue_directed();
        pending[$].hold = 1'b1;
        queue_req(FN_CLEAR, '0, 1'b0, '0, '0, 1'b1);
        while (pending.size() < 1000) queue_episode();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || n_offered != n_taken || results_due.size() != 0)
            @(negedge i_clk);
        repeat (MAX_ENTRIES + 8) @(negedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            n_fail++;
        end

        $display("%0d requests sent, %0d results checked", n_taken, n_checked);
        $display("outcomes: ok %0d, no entry %0d, expired %0d, not allowed %0d, rejected %0d",
                 status_seen[ST_OK], status_seen[ST_NO_ENTRY], status_seen[ST_EXPIRED],
                 status_seen[ST_NOT_ALLOWED], status_seen[ST_REJECTED]);
        if (n_fail == 0) begin
            $display("keyed_allow_list_with_expiry regression: pass");
        end else begin
            $display("keyed_allow_list_with_expiry regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("keyed_allow_list_with_expiry regression: fail");
        $finish;
    end

endmodule
